// File: sv/muskingum_cunge_coefficients_unit_macros.svh
// Assertion macros used by the coefficient unit RTL.
`ifndef MUSKINGUM_CUNGE_COEFFICIENTS_UNIT_MACROS_SVH
`define MUSKINGUM_CUNGE_COEFFICIENTS_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mcc_pkg.sv
// Types, widths and constants of the Muskingum-Cunge coefficient unit.
package mcc_pkg;

    // Result format
    localparam int COEFF_FRAC_BITS = 16;
    localparam int COEFF_W         = COEFF_FRAC_BITS + 1;
    localparam logic [COEFF_W-1:0] COEFF_ONE = {1'b1, {COEFF_FRAC_BITS{1'b0}}};

    // Time step register
    localparam int DT_W = 20;
    localparam logic [DT_W-1:0] DT_RESET = 20'd86400;

    // Input field widths
    localparam int Q_W  = 32;
    localparam int S_W  = 24;
    localparam int Y_W  = 20;
    localparam int WD_W = 24;
    localparam int B_W  = 16;
    localparam int L_W  = 24;

    // Celerity ratio terms: xn = 5*beta + 3*4096, xd = 3*beta + 3*4096
    localparam int XN_W = 18;
    localparam int XD_W = 17;
    localparam logic [XN_W-1:0] XN_BASE = 18'd12288;

    // Intermediate product widths
    localparam int XQ_W     = XN_W + Q_W;
    localparam int LS_W     = L_W + S_W;
    localparam int YX_W     = Y_W + XD_W;
    localparam int WL_W     = WD_W + L_W;
    localparam int DT_SHIFT = 10;
    localparam int CN_W     = XQ_W + DT_W + DT_SHIFT;
    localparam int CD_W     = YX_W + WL_W;
    localparam int DN_SC_W  = 16;
    localparam logic [DN_SC_W-1:0] DN_SCALE = 16'd64000;
    localparam int DN_W     = YX_W + DN_SC_W;
    localparam int DD_W     = LS_W + XN_W;
    localparam int CS_W     = CD_W + 1;

    // Wide multiplier built from 32x32 partial products
    localparam int LIMB_W = 32;
    localparam int LIMBS  = 3;
    localparam int MUL_W  = LIMB_W * LIMBS;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ROW_W  = MUL_W + LIMB_W;

    // Signed numerators and denominator
    localparam int WIDE_W = 160;

    // Pipeline depths
    localparam int FRONT_STAGES = 6;
    localparam int CROSS_STAGES = 6;
    localparam int DIV_STAGES   = COEFF_W;

    // Stream widths
    localparam int IN_FIELDS_W = Q_W + S_W + Y_W + WD_W + B_W + L_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * COEFF_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NEG_COEFF = 2'd2
    } t_status;

    typedef struct packed {
        logic              data_missing;
        logic [L_W-1:0]    reach_length;
        logic signed [B_W-1:0] shape_exponent;
        logic [WD_W-1:0]   mean_width;
        logic [Y_W-1:0]    mean_depth;
        logic signed [S_W-1:0] bed_slope;
        logic signed [Q_W-1:0] discharge;
    } t_reach;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_mul_en;

    typedef struct packed {
        logic            inv;
        logic            sneg;
        logic            diff_neg;
        logic [CD_W-1:0] cd;
        logic [CS_W-1:0] csum;
        logic [CD_W-1:0] cdiff;
        logic [DN_W-1:0] dn;
        logic [DD_W-1:0] dd;
    } t_front;

    typedef struct packed {
        logic                   inv;
        logic [WIDE_W-1:0]      den;
        logic [2:0][WIDE_W-1:0] num;
    } t_ratio;

    typedef struct packed {
        t_status                 status;
        logic [2:0][COEFF_W-1:0] coeff;
    } t_coeffs;

endpackage

// File: sv/mcc_mul96.sv
// Three-stage unsigned multiplier from 32x32 partial products.
module mcc_mul96 (
    input  logic                     i_clk,
    input  mcc_pkg::t_mul_en         i_en,
    input  logic [mcc_pkg::MUL_W-1:0]  i_a,
    input  logic [mcc_pkg::MUL_W-1:0]  i_b,
    output logic [mcc_pkg::PROD_W-1:0] o_p
);
    import mcc_pkg::*;

    logic [LIMBS-1:0][LIMBS-1:0][2*LIMB_W-1:0] r_pp;
    logic [LIMBS-1:0][ROW_W-1:0]               r_row;
    logic [LIMBS-1:0][ROW_W-1:0]               n_row;
    logic [PROD_W-1:0]                         r_p;
    logic [PROD_W-1:0]                         n_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int i = 0; i < LIMBS; i++) begin
                for (int j = 0; j < LIMBS; j++) begin
                    r_pp[i][j] <= (2*LIMB_W)'(i_a[i*LIMB_W +: LIMB_W])
                                * (2*LIMB_W)'(i_b[j*LIMB_W +: LIMB_W]);
                end
            end
        end
    end

    // one row per limb of a
    always_comb begin
        for (int i = 0; i < LIMBS; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < LIMBS; j++) begin
                n_row[i] = n_row[i] + (ROW_W'(r_pp[i][j]) << (j*LIMB_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_row <= n_row;
        end
    end

    // final sum
    always_comb begin
        n_p = '0;
        for (int i = 0; i < LIMBS; i++) begin
            n_p = n_p + (PROD_W'(r_row[i]) << (i*LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// File: sv/mcc_front.sv
// Front pipeline: validity checks, Courant and Reynolds ratio terms.
module mcc_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  mcc_pkg::t_reach         i_reach,
    input  logic [mcc_pkg::DT_W-1:0] i_dt,
    output logic                    o_valid,
    input  logic                    i_ready,
    output mcc_pkg::t_front         o_front
);
    import mcc_pkg::*;

    typedef struct packed {
        logic            inv;
        logic            sneg;
        logic [CN_W-1:0] cn;
        logic [DD_W-1:0] dd;
        logic [DN_W-1:0] dn;
    } t_mid;

    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES-1:0] en;

    // stage 0 registers
    logic            r0_inv, r0_sneg;
    logic [Q_W-1:0]  r0_qm;
    logic [S_W-1:0]  r0_sm;
    logic [Y_W-1:0]  r0_y;
    logic [WD_W-1:0] r0_w;
    logic [L_W-1:0]  r0_len;
    logic [XN_W-1:0] r0_xn;
    logic [XD_W-1:0] r0_xd;
    // stage 1 registers
    logic            r1_inv, r1_sneg;
    logic [XQ_W-1:0] r1_xq;
    logic [LS_W-1:0] r1_ls;
    logic [YX_W-1:0] r1_yx;
    logic [WL_W-1:0] r1_wl;
    logic [XN_W-1:0] r1_xn;
    // stages 2..4 and 5
    t_mid   r_mid [3];
    t_mid   n_mid;
    t_front r5;
    t_front n5;

    logic [XQ_W+DT_W-1:0] cn_raw;
    logic [PROD_W-1:0]    cd_prod;
    logic [CD_W-1:0]      cd;
    logic                 n_inv;
    logic [B_W-2:0]       beta;
    t_mul_en              mul_en;

    // stall chain: a stage moves when empty or when the next one moves
    always_comb begin
        en[FRONT_STAGES-1] = !r_v[FRONT_STAGES-1] || i_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < FRONT_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // stage 0: magnitudes, invalid-input flag, celerity terms
    assign n_inv = i_reach.data_missing || (i_reach.reach_length == '0)
                || (i_reach.discharge == '0) || (i_reach.bed_slope == '0)
                || (i_reach.mean_depth == '0) || (i_reach.mean_width == '0)
                || i_reach.shape_exponent[B_W-1];
    assign beta = i_reach.shape_exponent[B_W-2:0];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_inv  <= n_inv;
            r0_sneg <= i_reach.bed_slope[S_W-1];
            r0_qm   <= i_reach.discharge[Q_W-1] ? Q_W'(-i_reach.discharge)
                                                : Q_W'(i_reach.discharge);
            r0_sm   <= i_reach.bed_slope[S_W-1] ? S_W'(-i_reach.bed_slope)
                                                : S_W'(i_reach.bed_slope);
            r0_y    <= i_reach.mean_depth;
            r0_w    <= i_reach.mean_width;
            r0_len  <= i_reach.reach_length;
            r0_xn   <= XN_W'(beta) * XN_W'(5) + XN_BASE;
            r0_xd   <= XD_W'(beta) * XD_W'(3) + XD_W'(XN_BASE);
        end
    end

    // stage 1: first products
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_inv  <= r0_inv;
            r1_sneg <= r0_sneg;
            r1_xq   <= XQ_W'(r0_xn) * XQ_W'(r0_qm);
            r1_ls   <= LS_W'(r0_len) * LS_W'(r0_sm);
            r1_yx   <= YX_W'(r0_y) * YX_W'(r0_xd);
            r1_wl   <= WL_W'(r0_w) * WL_W'(r0_len);
            r1_xn   <= r0_xn;
        end
    end

    // stage 2: Courant numerator, Reynolds terms; depth product goes to the wide multiplier
    assign cn_raw = (XQ_W+DT_W)'(r1_xq) * (XQ_W+DT_W)'(i_dt);

    always_comb begin
        n_mid.inv  = r1_inv;
        n_mid.sneg = r1_sneg;
        n_mid.cn   = {cn_raw, {DT_SHIFT{1'b0}}};
        n_mid.dd   = DD_W'(r1_ls) * DD_W'(r1_xn);
        n_mid.dn   = DN_W'(r1_yx) * DN_W'(DN_SCALE);
    end

    assign mul_en.s1 = en[2];
    assign mul_en.s2 = en[3];
    assign mul_en.s3 = en[4];

    mcc_mul96 u_mul_cd (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (MUL_W'(r1_yx)),
        .i_b   (MUL_W'(r1_wl)),
        .o_p   (cd_prod)
    );

    // stages 2..4: align with the wide multiplier
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_mid[0] <= n_mid;
        end
        if (en[3]) begin
            r_mid[1] <= r_mid[0];
        end
        if (en[4]) begin
            r_mid[2] <= r_mid[1];
        end
    end

    // stage 5: cd + cn and |cd - cn|
    assign cd = cd_prod[CD_W-1:0];

    always_comb begin
        n5.inv      = r_mid[2].inv;
        n5.sneg     = r_mid[2].sneg;
        n5.diff_neg = CD_W'(r_mid[2].cn) > cd;
        n5.cd       = cd;
        n5.csum     = CS_W'(cd) + CS_W'(r_mid[2].cn);
        n5.cdiff    = n5.diff_neg ? CD_W'(r_mid[2].cn) - cd : cd - CD_W'(r_mid[2].cn);
        n5.dn       = r_mid[2].dn;
        n5.dd       = r_mid[2].dd;
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5 <= n5;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_front = r5;

endmodule

// File: sv/mcc_cross.sv
// Cross products, numerators and denominator, sign normalization.
module mcc_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mcc_pkg::t_front i_front,
    output logic            o_valid,
    input  logic            i_ready,
    output mcc_pkg::t_ratio o_ratio
);
    import mcc_pkg::*;

    typedef struct packed {
        logic inv;
        logic sneg;
        logic diff_neg;
    } t_flags;

    logic [CROSS_STAGES-1:0] r_v;
    logic [CROSS_STAGES-1:0] en;

    t_flags            r_fl [3];
    logic [PROD_W-1:0] p_prod, m_prod, d_prod;
    t_mul_en           mul_en;

    logic [WIDE_W-1:0] p, dcm, mm, dcx, dcc, mx, mc, nmx, nmc;
    t_ratio            n3, r3, r4, r5, n5;
    logic              r4_neg;

    // stall chain
    always_comb begin
        en[CROSS_STAGES-1] = !r_v[CROSS_STAGES-1] || i_ready;
        for (int k = CROSS_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < CROSS_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // stages 0..2: three wide products
    assign mul_en.s1 = en[0];
    assign mul_en.s2 = en[1];
    assign mul_en.s3 = en[2];

    mcc_mul96 u_mul_p (
        .i_clk (i_clk), .i_en (mul_en),
        .i_a (MUL_W'(i_front.csum)), .i_b (MUL_W'(i_front.dd)), .o_p (p_prod)
    );

    mcc_mul96 u_mul_m (
        .i_clk (i_clk), .i_en (mul_en),
        .i_a (MUL_W'(i_front.cdiff)), .i_b (MUL_W'(i_front.dd)), .o_p (m_prod)
    );

    mcc_mul96 u_mul_d (
        .i_clk (i_clk), .i_en (mul_en),
        .i_a (MUL_W'(i_front.dn)), .i_b (MUL_W'(i_front.cd)), .o_p (d_prod)
    );

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_fl[0] <= '{inv: i_front.inv, sneg: i_front.sneg, diff_neg: i_front.diff_neg};
        end
        if (en[1]) begin
            r_fl[1] <= r_fl[0];
        end
        if (en[2]) begin
            r_fl[2] <= r_fl[1];
        end
    end

    // stage 3: den = P + dc, n1 = P - dc, n0 = dc - M, n2 = M + dc
    // signed terms enter as one's complement plus a carry
    always_comb begin
        p   = WIDE_W'(p_prod);
        dcm = WIDE_W'(d_prod);
        mm  = WIDE_W'(m_prod);
        dcx = r_fl[2].sneg ? ~dcm : dcm;
        dcc = WIDE_W'(r_fl[2].sneg);
        mx  = r_fl[2].diff_neg ? ~mm : mm;
        mc  = WIDE_W'(r_fl[2].diff_neg);
        nmx = r_fl[2].diff_neg ? mm : ~mm;
        nmc = WIDE_W'(!r_fl[2].diff_neg);
        n3.inv    = r_fl[2].inv;
        n3.den    = p + dcx + dcc;
        n3.num[1] = p + (r_fl[2].sneg ? dcm : ~dcm) + WIDE_W'(!r_fl[2].sneg);
        n3.num[0] = dcx + nmx + dcc + nmc;
        n3.num[2] = mx + dcx + mc + dcc;
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3 <= n3;
        end
    end

    // stage 4: zero denominator joins the invalid flag
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4     <= '{inv: r3.inv || (r3.den == '0), den: r3.den, num: r3.num};
            r4_neg <= r3.den[WIDE_W-1];
        end
    end

    // stage 5: make the denominator positive, negating the numerators with it
    always_comb begin
        n5.inv = r4.inv;
        n5.den = r4_neg ? (~r4.den + WIDE_W'(1)) : r4.den;
        for (int j = 0; j < 3; j++) begin
            n5.num[j] = r4_neg ? (~r4.num[j] + WIDE_W'(1)) : r4.num[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5 <= n5;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[CROSS_STAGES-1];
    assign o_ratio = r5;

endmodule

// File: sv/mcc_div.sv
// Bit-per-stage restoring divider for the three coefficients, with status.
`include "muskingum_cunge_coefficients_unit_macros.svh"

module mcc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mcc_pkg::t_ratio  i_ratio,
    output logic             o_valid,
    input  logic             i_ready,
    output mcc_pkg::t_coeffs o_coeffs
);
    import mcc_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] en;

    t_status                 r_st  [DIV_STAGES];
    logic [2:0][COEFF_W-1:0] r_q   [DIV_STAGES];
    logic [2:0][WIDE_W-1:0]  r_rem [LAST];
    logic [WIDE_W-1:0]       r_den [LAST];

    t_status           st0;
    logic [COEFF_W+1:0] qsum;

    // stall chain
    always_comb begin
        en[LAST] = !r_v[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // result status from flags and numerator signs
    always_comb begin
        if (i_ratio.inv) begin
            st0 = ST_INVALID;
        end else if (i_ratio.num[0][WIDE_W-1] || i_ratio.num[1][WIDE_W-1]
                     || i_ratio.num[2][WIDE_W-1]) begin
            st0 = ST_NEG_COEFF;
        end else begin
            st0 = ST_OK;
        end
    end

    // one quotient bit per stage for each numerator
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [2:0][WIDE_W-1:0]  trial;
        logic [2:0][WIDE_W-1:0]  rem;
        logic [2:0][COEFF_W-1:0] q;
        logic [2:0][COEFF_W-1:0] q_prev;
        logic [WIDE_W-1:0]       den;
        t_status                 st;

        // stage inputs: the ratio for the first stage, the previous stage otherwise
        if (k == 0) begin : g_first
            assign den    = i_ratio.den;
            assign st     = st0;
            assign trial  = i_ratio.num;
            assign q_prev = '0;
        end else begin : g_next
            assign den    = r_den[k-1];
            assign st     = r_st[k-1];
            assign q_prev = r_q[k-1];
            for (genvar j = 0; j < 3; j++) begin : g_shift
                assign trial[j] = {r_rem[k-1][j][WIDE_W-2:0], 1'b0};
            end
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                if (trial[j] >= den) begin
                    rem[j] = trial[j] - den;
                end else begin
                    rem[j] = trial[j];
                end
                q[j] = {q_prev[j][COEFF_W-2:0], trial[j] >= den};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_st[k] <= st;
                r_q[k]  <= q;
            end
        end

        if (k < LAST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_rem[k] <= rem;
                    r_den[k] <= den;
                end
            end
        end
    end

    // fallback (1, 0, 0) for either failure
    always_comb begin
        o_coeffs.status = r_st[LAST];
        if (r_st[LAST] == ST_OK) begin
            o_coeffs.coeff = r_q[LAST];
        end else begin
            o_coeffs.coeff[0] = COEFF_ONE;
            o_coeffs.coeff[1] = '0;
            o_coeffs.coeff[2] = '0;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[LAST];
    assign qsum = (COEFF_W+2)'(o_coeffs.coeff[0]) + (COEFF_W+2)'(o_coeffs.coeff[1])
                + (COEFF_W+2)'(o_coeffs.coeff[2]);

    // truncated coefficients sum to one, less at most two units
    `MCC_ASSERT_NOW(a_sum_near_one, o_valid && (o_coeffs.status == ST_OK),
        (qsum <= (COEFF_W+2)'(COEFF_ONE)) && (qsum + 2 >= (COEFF_W+2)'(COEFF_ONE)),
        "coefficient sum off one")
    `MCC_ASSERT_NOW(a_fallback_vals, o_valid && (o_coeffs.status != ST_OK),
        (o_coeffs.coeff[0] == COEFF_ONE) && (o_coeffs.coeff[1] == '0),
        "fallback result wrong")
    `MCC_ASSERT_NEXT(a_stall_holds, r_v[0] && !en[0], r_v[0],
        "stalled divider stage dropped its item")

endmodule

// File: sv/muskingum_cunge_coefficients_unit.sv
// Top level of the Muskingum-Cunge routing coefficient unit.
// Each reach goes in and its C0, C1, C2 (16 fraction bits) and status come out
// through the front end (magnitudes, ratio terms, one three-stage wide multiply),
// the cross-product stage (three three-stage wide multiplies, combine, sign fix)
// and the divider, which resolves one quotient bit per stage. The sustained rate
// is one reach per cycle when the output side is not stalled. Empty stages close
// up under backpressure, so input requests are taken while a finished result
// waits. The time step register is written through the cfg channel, which is
// always ready; write it only while no reach is in flight.
module muskingum_cunge_coefficients_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // reach input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // discharge, bed_slope, mean_depth, mean_width, shape_exponent, reach_length
    input  logic [mcc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // data_missing
    input  logic                               s_axis_tuser,
    // coefficient output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // coeff_current_inflow, coeff_previous_inflow, coeff_previous_outflow
    output logic [mcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_status
    output logic [1:0]                         m_axis_tuser,
    // time step register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mcc_pkg::DT_W-1:0]           i_cfg_data
);
    import mcc_pkg::*;

    logic [DT_W-1:0] r_dt;
    t_reach          reach;
    t_front          front;
    t_ratio          ratio;
    t_coeffs         coeffs;
    logic            f_valid, x_ready, x_valid, d_ready;

    // time step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
        end else if (i_cfg_valid) begin
            r_dt <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // unpack the request
    assign reach = t_reach'({s_axis_tuser, s_axis_tdata[IN_FIELDS_W-1:0]});

    mcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_reach (reach),
        .i_dt    (r_dt),
        .o_valid (f_valid),
        .i_ready (x_ready),
        .o_front (front)
    );

    mcc_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (x_ready),
        .i_front (front),
        .o_valid (x_valid),
        .i_ready (d_ready),
        .o_ratio (ratio)
    );

    mcc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (x_valid),
        .o_ready  (d_ready),
        .i_ratio  (ratio),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_coeffs (coeffs)
    );

    // pack the result
    assign m_axis_tdata = OUT_TDATA_W'({coeffs.coeff[2], coeffs.coeff[1], coeffs.coeff[0]});
    assign m_axis_tuser = coeffs.status;

endmodule
